>>> src/mwc_pkg.sv
// Shared types and constants of the memory usage watermark counters.
package mwc_pkg;

  localparam int NumCategoriesDef = 14;
  localparam int NumHeapsDef      = 16;
  localparam int MaskBits         = 32;

  // compare widths wide enough for any legal parameter value
  localparam int LimitCmpW = 6;
  localparam int RowCmpW   = 7;

  typedef enum logic [1:0] {
    ReqAlloc   = 2'd0,
    ReqFree    = 2'd1,
    ReqReclass = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [63:0] requested_bytes;
    logic [63:0] committed_bytes;
    logic [5:0]  type_index;
    logic [4:0]  heap_index;
  } event_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       handle_valid;
    logic [3:0] category;
    logic [3:0] new_category;
    event_t     ev;
    logic [4:0] read_row;
  } request_t;

  typedef struct packed {
    logic       accepted;
    logic       handle_valid_out;
    logic [3:0] handle_category_out;
  } verdict_t;

  typedef struct packed {
    logic [63:0] requested_live;
    logic [63:0] requested_peak;
    logic [63:0] committed_live;
    logic [63:0] committed_peak;
    logic [31:0] live_count;
    logic [31:0] peak_count;
    logic [31:0] type_mask;
    logic [31:0] heap_mask;
  } row_t;

endpackage

>>> src/mwc_if.sv
// Request and result channel interfaces of the watermark counters.
interface mwc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        handle_valid;
  logic [3:0]  category;
  logic [3:0]  new_category;
  logic [63:0] requested_bytes;
  logic [63:0] committed_bytes;
  logic [5:0]  type_index;
  logic [4:0]  heap_index;
  logic [4:0]  read_row;

  modport source (
    output valid, req_type, handle_valid, category, new_category,
           requested_bytes, committed_bytes, type_index, heap_index, read_row,
    input  ready
  );
  modport sink (
    input  valid, req_type, handle_valid, category, new_category,
           requested_bytes, committed_bytes, type_index, heap_index, read_row,
    output ready
  );
endinterface

interface mwc_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        handle_valid_out;
  logic [3:0]  handle_category_out;
  logic [63:0] row_requested_live;
  logic [63:0] row_requested_peak;
  logic [63:0] row_committed_live;
  logic [63:0] row_committed_peak;
  logic [31:0] row_live_count;
  logic [31:0] row_peak_count;
  logic [31:0] row_type_mask;
  logic [31:0] row_heap_mask;

  modport source (
    output valid, accepted, handle_valid_out, handle_category_out,
           row_requested_live, row_requested_peak, row_committed_live,
           row_committed_peak, row_live_count, row_peak_count,
           row_type_mask, row_heap_mask,
    input  ready
  );
  modport sink (
    input  valid, accepted, handle_valid_out, handle_category_out,
           row_requested_live, row_requested_peak, row_committed_live,
           row_committed_peak, row_live_count, row_peak_count,
           row_type_mask, row_heap_mask,
    output ready
  );
endinterface

>>> src/mwc_decode.sv
// Event decode: acceptance checks, record update and per-row add/sub strobes.
module mwc_decode #(
  parameter int NUM_CATEGORIES = mwc_pkg::NumCategoriesDef,
  parameter int NUM_HEAPS      = mwc_pkg::NumHeapsDef,
  localparam int NumRows       = NUM_CATEGORIES + NUM_HEAPS + 1
) (
  input  mwc_pkg::request_t req_i,
  output mwc_pkg::verdict_t verdict_o,
  output logic [NumRows-1:0] add_o,
  output logic [NumRows-1:0] sub_o
);

  logic cat_ok, ncat_ok, heap_ok;
  logic alloc_ok, free_ok, recl_ok;
  logic [mwc_pkg::RowCmpW-1:0] heap_row, total_row, cat_row, ncat_row;

  assign cat_ok  = {2'b0, req_i.category} < mwc_pkg::LimitCmpW'(NUM_CATEGORIES);
  assign ncat_ok = {2'b0, req_i.new_category} < mwc_pkg::LimitCmpW'(NUM_CATEGORIES);
  assign heap_ok = {1'b0, req_i.ev.heap_index} < mwc_pkg::LimitCmpW'(NUM_HEAPS);

  assign cat_row   = {3'b0, req_i.category};
  assign ncat_row  = {3'b0, req_i.new_category};
  assign heap_row  = mwc_pkg::RowCmpW'(NUM_CATEGORIES) + {2'b0, req_i.ev.heap_index};
  assign total_row = mwc_pkg::RowCmpW'(NUM_CATEGORIES + NUM_HEAPS);

  always_comb begin
    alloc_ok  = 1'b0;
    free_ok   = 1'b0;
    recl_ok   = 1'b0;
    verdict_o = '{accepted: 1'b0, handle_valid_out: req_i.handle_valid,
                  handle_category_out: req_i.category};
    case (req_i.req_type)
      mwc_pkg::ReqAlloc: begin
        alloc_ok = !req_i.handle_valid && cat_ok && heap_ok;
        if (alloc_ok) begin
          verdict_o.accepted         = 1'b1;
          verdict_o.handle_valid_out = 1'b1;
        end
      end
      mwc_pkg::ReqFree: begin
        // drop the record even when the free is not applied
        free_ok = req_i.handle_valid && cat_ok && heap_ok;
        verdict_o.accepted            = free_ok;
        verdict_o.handle_valid_out    = 1'b0;
        verdict_o.handle_category_out = '0;
      end
      mwc_pkg::ReqReclass: begin
        recl_ok = req_i.handle_valid && ncat_ok && cat_ok &&
                  (req_i.new_category != req_i.category);
        if (recl_ok) begin
          verdict_o.accepted            = 1'b1;
          verdict_o.handle_valid_out    = 1'b1;
          verdict_o.handle_category_out = req_i.new_category;
        end
      end
      default: ;
    endcase
  end

  for (genvar r = 0; r < NumRows; r++) begin : g_strobe
    logic is_cat, is_ncat, is_heap, is_total;
    assign is_cat   = mwc_pkg::RowCmpW'(r) == cat_row;
    assign is_ncat  = mwc_pkg::RowCmpW'(r) == ncat_row;
    assign is_heap  = mwc_pkg::RowCmpW'(r) == heap_row;
    assign is_total = mwc_pkg::RowCmpW'(r) == total_row;
    assign add_o[r] = (alloc_ok && (is_cat || is_heap || is_total)) || (recl_ok && is_ncat);
    assign sub_o[r] = (free_ok && (is_cat || is_heap || is_total)) || (recl_ok && is_cat);
  end

endmodule

>>> src/mwc_row.sv
// One counter row: live and peak sums, counts and seen masks.
module mwc_row (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             add_i,
  input  logic             sub_i,
  input  mwc_pkg::event_t  ev_i,
  output mwc_pkg::row_t    row_o
);

  mwc_pkg::row_t row_d, row_q;

  always_comb begin
    logic [63:0] req_sum, com_sum;
    logic [31:0] cnt_sum;
    req_sum = row_q.requested_live + ev_i.requested_bytes;
    com_sum = row_q.committed_live + ev_i.committed_bytes;
    cnt_sum = row_q.live_count + 32'd1;
    row_d   = row_q;
    if (add_i) begin
      row_d.requested_live = req_sum;
      row_d.committed_live = com_sum;
      row_d.live_count     = cnt_sum;
      if (req_sum > row_q.requested_peak) row_d.requested_peak = req_sum;
      if (com_sum > row_q.committed_peak) row_d.committed_peak = com_sum;
      if (cnt_sum > row_q.peak_count)     row_d.peak_count     = cnt_sum;
      // type indices past the mask width leave no trace
      if (!ev_i.type_index[5]) row_d.type_mask[ev_i.type_index[4:0]] = 1'b1;
      row_d.heap_mask[ev_i.heap_index] = 1'b1;
    end else if (sub_i) begin
      // saturate at zero
      row_d.requested_live = (row_q.requested_live >= ev_i.requested_bytes) ?
                             row_q.requested_live - ev_i.requested_bytes : '0;
      row_d.committed_live = (row_q.committed_live >= ev_i.committed_bytes) ?
                             row_q.committed_live - ev_i.committed_bytes : '0;
      if (row_q.live_count != '0) row_d.live_count = row_q.live_count - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

>>> src/memory_usage_watermark_counters_core.sv
// Top level of the memory usage watermark counters.
// Keeps NUM_CATEGORIES + NUM_HEAPS + 1 counter rows (category rows first, then
// heap rows, then the grand total) in flip-flops, all zero after reset. Each
// request is an allocation, a free or a reclassify; it updates up to three rows
// and returns one result with the acceptance verdict, the caller's new record
// mark and a readback of the row named by read_row after the update (rows at or
// above the row count read as zero). A request passes three registers: the
// request register, the counter rows (every row has its own adder and peak
// compare, updated at the edge that leaves the request register) and the result
// register, and a new request is taken every cycle while the result register
// is not stalled. The readback mux works on the row registers, which always
// hold the state left by the request being read back. A result that is not
// taken stalls the whole pipe; req_i.ready is !out_valid_q || rsp_o.ready.
module memory_usage_watermark_counters_core #(
  parameter int NUM_CATEGORIES = mwc_pkg::NumCategoriesDef,
  parameter int NUM_HEAPS      = mwc_pkg::NumHeapsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mwc_req_if.sink   req_i,
  mwc_rsp_if.source rsp_o
);

  localparam int NumRows  = NUM_CATEGORIES + NUM_HEAPS + 1;
  localparam int ReadRows = (NumRows < mwc_pkg::MaskBits) ? NumRows : mwc_pkg::MaskBits;

  logic advance;

  // request stage
  logic               s1_valid_q;
  mwc_pkg::request_t  s1_req_q;

  // update stage results
  mwc_pkg::verdict_t  verdict;
  logic [NumRows-1:0] add_row, sub_row;
  logic               s2_valid_q;
  mwc_pkg::verdict_t  s2_verdict_q;
  logic [4:0]         s2_row_q;

  // counter rows
  mwc_pkg::row_t      rows [NumRows];
  mwc_pkg::row_t      sel_row;

  // result register
  logic               out_valid_q;
  mwc_pkg::verdict_t  out_verdict_q;
  mwc_pkg::row_t      out_row_q;

  // move the pipe whenever the result slot is free or being emptied
  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= req_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (advance && req_i.valid) begin
      s1_req_q.req_type           <= req_i.req_type;
      s1_req_q.handle_valid       <= req_i.handle_valid;
      s1_req_q.category           <= req_i.category;
      s1_req_q.new_category       <= req_i.new_category;
      s1_req_q.ev.requested_bytes <= req_i.requested_bytes;
      s1_req_q.ev.committed_bytes <= req_i.committed_bytes;
      s1_req_q.ev.type_index      <= req_i.type_index;
      s1_req_q.ev.heap_index      <= req_i.heap_index;
      s1_req_q.read_row           <= req_i.read_row;
    end
  end

  mwc_decode #(
    .NUM_CATEGORIES (NUM_CATEGORIES),
    .NUM_HEAPS      (NUM_HEAPS)
  ) u_decode (
    .req_i     (s1_req_q),
    .verdict_o (verdict),
    .add_o     (add_row),
    .sub_o     (sub_row)
  );

  // every row watches the broadcast event and updates itself
  for (genvar r = 0; r < NumRows; r++) begin : g_row
    mwc_row u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .add_i  (advance && s1_valid_q && add_row[r]),
      .sub_i  (advance && s1_valid_q && sub_row[r]),
      .ev_i   (s1_req_q.ev),
      .row_o  (rows[r])
    );
  end

  // hold the verdict and readback row while the rows settle
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      s2_verdict_q <= verdict;
      s2_row_q     <= s1_req_q.read_row;
    end
  end

  // readback select; rows past the end read zero
  always_comb begin
    sel_row = '0;
    for (int r = 0; r < ReadRows; r++) begin
      if (s2_row_q == 5'(r)) sel_row = rows[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      out_verdict_q <= s2_verdict_q;
      out_row_q     <= sel_row;
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.accepted            = out_verdict_q.accepted;
  assign rsp_o.handle_valid_out    = out_verdict_q.handle_valid_out;
  assign rsp_o.handle_category_out = out_verdict_q.handle_category_out;
  assign rsp_o.row_requested_live  = out_row_q.requested_live;
  assign rsp_o.row_requested_peak  = out_row_q.requested_peak;
  assign rsp_o.row_committed_live  = out_row_q.committed_live;
  assign rsp_o.row_committed_peak  = out_row_q.committed_peak;
  assign rsp_o.row_live_count      = out_row_q.live_count;
  assign rsp_o.row_peak_count      = out_row_q.peak_count;
  assign rsp_o.row_type_mask       = out_row_q.type_mask;
  assign rsp_o.row_heap_mask       = out_row_q.heap_mask;

endmodule

>>> src/mwc_checker.sv
// Port-level checks of the watermark counters, bound to the top level.
module mwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [63:0] requested_live_i,
  input logic [63:0] requested_peak_i,
  input logic [63:0] committed_live_i,
  input logic [63:0] committed_peak_i,
  input logic [31:0] live_count_i,
  input logic [31:0] peak_count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(live_count_i) &&
                                    $stable(requested_live_i))
    else $error("result changed while stalled");

  a_req_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> requested_live_i <= requested_peak_i)
    else $error("requested live above its peak");

  a_com_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> committed_live_i <= committed_peak_i)
    else $error("committed live above its peak");

  a_cnt_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> live_count_i <= peak_count_i)
    else $error("live count above its peak");

endmodule

bind memory_usage_watermark_counters_core mwc_checker u_mwc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .requested_live_i (rsp_o.row_requested_live),
  .requested_peak_i (rsp_o.row_requested_peak),
  .committed_live_i (rsp_o.row_committed_live),
  .committed_peak_i (rsp_o.row_committed_peak),
  .live_count_i     (rsp_o.row_live_count),
  .peak_count_i     (rsp_o.row_peak_count)
);
